// File: design/rid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rolling identifier allocator package
// Shared widths, operation and status codes, sequencer states and the
// word-level priority encoder used by the in-use map scan.
// ----------------------------------------------------------------------------
package rid_pkg;

   // Identifier space and map organisation.
   localparam int ID_W        = 14;
   localparam int ID_SPACE    = 1 << ID_W;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int WORDS       = ID_SPACE / WORD_W;
   localparam int ADDR_W      = $clog2(WORDS);
   localparam int SCAN_CNT_W  = $clog2(WORDS + 1);
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int SLOTS_DEFAULT = 64;

   // Operation codes; the unused code is decoded as a query.
   localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_IN_USE = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_EVAL
   } state_type;

   // Result of a search for the lowest set bit of a map word.
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] index;
   } first_set_type;

   // Lowest set bit of a word; found is low when the word is zero.
   function automatic first_set_type first_set(input logic [WORD_W-1:0] word);
      first_set_type res;
      res.found = 1'b0;
      res.index = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            res.found = 1'b1;
            res.index = BIT_W'(i);
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: design/rid_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: design/rolling_id_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rolling identifier allocator
// Next-fit allocator of identifiers 1 to 16383 with a bounded number of
// live identifiers, backed by a word-wide in-use map in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer on req_ carries an operation (allocate, release or
//   query) and an identifier. Each request gives exactly one result
//   transfer on rsp_: the identifier given or echoed, and a status.
//   After reset the block clears the 512-word in-use map, one word per
//   cycle, and holds req_ready low until the clearing pass is done.
//   Release and query are taken in S_IDLE, read their map word in S_LOOK
//   and are decided, updated and answered in S_EVAL; a new request is
//   taken only once the last one is through. An allocate scans the map
//   one 32-bit word at a time, each through S_LOOK and S_EVAL, from the
//   word holding the identifier after the last one given, until it finds
//   a free identifier or has seen every word.
//   A full allocator answers after the first read.
//   The result sits in an output register; while the receiver stalls,
//   the next request is taken and worked up to its map update, which
//   waits until the held result is transferred.
// ----------------------------------------------------------------------------
module rolling_id_allocator_unit #(
   parameter int SLOTS = rid_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [rid_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [rid_pkg::ID_W-1:0]      req_id_in,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [rid_pkg::ID_W-1:0]      rsp_id_out,
   output      logic [rid_pkg::STATUS_W-1:0]  rsp_status
);

   import rid_pkg::*;

   localparam int LIVE_W = $clog2(SLOTS + 1);

   // Sequencer and request registers.
   state_type              state_ff, state_in;
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [ADDR_W-1:0]      scan_addr_ff, scan_addr_in;
   logic [SCAN_CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [BIT_W-1:0]       start_bit_ff, start_bit_in;

   // Allocator state.
   logic [ID_W-1:0]        last_given_ff, last_given_in;
   logic [LIVE_W-1:0]      live_count_ff, live_count_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // Map RAM ports.
   logic                   ram_wr_en;
   logic [WORD_W-1:0]      ram_wr_data;
   logic [WORD_W-1:0]      ram_rd_data;

   // Scan helpers.
   logic [ID_W-1:0]        next_start;
   logic [WORD_W-1:0]      scan_mask;
   logic [WORD_W-1:0]      free_bits;
   first_set_type          hit;
   logic [WORD_W-1:0]      id_onehot;
   logic                   id_bit;
   logic                   rsp_free;
   logic                   slots_full;

   rid_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_addr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rd_data)
   );

   // Search window inside the word being examined. The first word starts
   // at the bit after the last identifier given, the final revisit of that
   // word stops just below it, and identifier zero is never offered.
   always_comb begin
      next_start = last_given_ff + ID_W'(1);
      scan_mask  = '1;
      if (scan_cnt_ff == SCAN_CNT_W'(0)) begin
         scan_mask = '1 << start_bit_ff;
      end else if (scan_cnt_ff == SCAN_CNT_W'(WORDS)) begin
         scan_mask = ~('1 << start_bit_ff);
      end
      if (scan_addr_ff == '0) begin
         scan_mask[0] = 1'b0;
      end
      free_bits  = ~ram_rd_data & scan_mask;
      hit        = first_set(free_bits);
      id_onehot  = WORD_W'(1) << id_ff[BIT_W-1:0];
      id_bit     = ram_rd_data[id_ff[BIT_W-1:0]] && (id_ff != '0);
      rsp_free   = !rsp_valid_ff || rsp_ready;
      slots_full = live_count_ff >= LIVE_W'(SLOTS);
   end

   // Next state and datapath.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      scan_addr_in  = scan_addr_ff;
      scan_cnt_in   = scan_cnt_ff;
      start_bit_in  = start_bit_ff;
      last_given_in = last_given_ff;
      live_count_in = live_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = ram_rd_data;
      req_ready     = 1'b0;

      unique case (state_ff)
         // Clearing pass over the map after reset.
         S_CLEAR: begin
            ram_wr_en    = 1'b1;
            ram_wr_data  = '0;
            scan_addr_in = scan_addr_ff + ADDR_W'(1);
            if (scan_addr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         // Take a request and point the map read at its first word.
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in      = req_func;
               id_in        = req_id_in;
               scan_cnt_in  = '0;
               start_bit_in = next_start[BIT_W-1:0];
               if (req_func == FN_ALLOC) begin
                  scan_addr_in = next_start[ID_W-1:BIT_W];
               end else begin
                  scan_addr_in = req_id_in[ID_W-1:BIT_W];
               end
               state_in = S_LOOK;
            end
         end

         // Map read in flight.
         S_LOOK: begin
            state_in = S_EVAL;
         end

         // Map word available: decide, update and answer.
         S_EVAL: begin
            if (func_ff == FN_ALLOC) begin
               if (slots_full || (!hit.found && scan_cnt_ff == SCAN_CNT_W'(WORDS))) begin
                  if (rsp_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = '0;
                     rsp_status_in = STAT_FULL;
                     state_in      = S_IDLE;
                  end
               end else if (hit.found) begin
                  if (rsp_free) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = ram_rd_data | (WORD_W'(1) << hit.index);
                     last_given_in = {scan_addr_ff, hit.index};
                     live_count_in = live_count_ff + LIVE_W'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = {scan_addr_ff, hit.index};
                     rsp_status_in = STAT_OK;
                     state_in      = S_IDLE;
                  end
               end else begin
                  scan_addr_in = scan_addr_ff + ADDR_W'(1);
                  scan_cnt_in  = scan_cnt_ff + SCAN_CNT_W'(1);
                  state_in     = S_LOOK;
               end
            end else if (func_ff == FN_RELEASE) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = id_ff;
                  if (id_bit) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = ram_rd_data & ~id_onehot;
                     if (live_count_ff != '0) begin
                        live_count_in = live_count_ff - LIVE_W'(1);
                     end
                     rsp_status_in = STAT_OK;
                  end else begin
                     rsp_status_in = STAT_NOT_IN_USE;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = id_ff;
                  rsp_status_in = id_bit ? STAT_OK : STAT_NOT_IN_USE;
                  state_in      = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         scan_addr_ff  <= '0;
         scan_cnt_ff   <= '0;
         last_given_ff <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_addr_ff  <= scan_addr_in;
         scan_cnt_ff   <= scan_cnt_in;
         last_given_ff <= last_given_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      id_ff         <= id_in;
      start_bit_ff  <= start_bit_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_id_out = rsp_id_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire
